// ===== hw/rtl/dual_motor_deadband_ramp_defines.svh =====
// ---------------------------------------------------------------------------
// dual motor deadband ramp assertion macros
// shared assertion forms for the motor ramp rtl
// ---------------------------------------------------------------------------
`ifndef DUAL_MOTOR_DEADBAND_RAMP_DEFINES_SVH
`define DUAL_MOTOR_DEADBAND_RAMP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define DMDR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define DMDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dmdr_pkg.sv =====
// ---------------------------------------------------------------------------
// dmdr_pkg
// shared types, constants and the ramp function of the motor ramp block
// ---------------------------------------------------------------------------
package dmdr_pkg;

   localparam int DUTY_W = 12;

   // item kinds
   localparam logic [1:0] KIND_LEFT  = 2'd0;
   localparam logic [1:0] KIND_RIGHT = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // stick mapping
   localparam logic [DUTY_W-1:0] LOW_RANGE_TOP   = 12'd2000;
   localparam logic [DUTY_W-1:0] HIGH_RANGE_BASE = 12'd2095;
   localparam logic [DUTY_W-1:0] RAMP_RESET      = 12'd50;

   // x*4095/2000 = 2x + x*19/400; x*19/400 taken as (x*49808) >> 20,
   // exact for x up to 2000
   localparam int               SPAN_W      = 11;
   localparam int               RECIP_W     = 16;
   localparam int               RECIP_SHIFT = 20;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 16'd49808;
   localparam int               PROD_W      = SPAN_W + RECIP_W;

   typedef logic [DUTY_W-1:0] duty_type;

   typedef struct packed {
      duty_type target;
      logic     dir_load;
      logic     dir_val;
   } map_result_type;

   // move speed toward target by step, never past it
   function automatic duty_type ramp_toward(duty_type speed, duty_type target,
                                            duty_type step);
      duty_type diff;
      duty_type result;
      diff   = '0;
      result = speed;
      if (speed < target) begin
         diff = target - speed;
         result = (diff <= step) ? target : duty_type'(speed + step);
      end else if (speed > target) begin
         diff = speed - target;
         result = (diff <= step) ? target : duty_type'(speed - step);
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/dmdr_map.sv =====
// ---------------------------------------------------------------------------
// dmdr_map
// maps a stick command to a target duty and a direction update
// ---------------------------------------------------------------------------
module dmdr_map (
   input  dmdr_pkg::duty_type       cmd,
   output dmdr_pkg::map_result_type result
);
   import dmdr_pkg::*;

   logic                low_range;
   logic                high_range;
   duty_type            high_off;
   logic [SPAN_W-1:0]   span;
   logic [PROD_W-1:0]   prod;
   duty_type            scaled;

   assign low_range  = (cmd <= LOW_RANGE_TOP);
   assign high_range = (cmd >= HIGH_RANGE_BASE);
   assign high_off   = cmd - HIGH_RANGE_BASE;
   assign span       = low_range ? cmd[SPAN_W-1:0] : high_off[SPAN_W-1:0];

   // fractional part of the 4095/2000 gain
   assign prod   = PROD_W'(span) * PROD_W'(RECIP_MULT);
   assign scaled = duty_type'({span, 1'b0})
                 + duty_type'(prod[PROD_W-1:RECIP_SHIFT]);

   always_comb begin
      result.target   = (low_range || high_range) ? scaled : '0;
      result.dir_load = low_range || high_range;
      result.dir_val  = high_range;
   end

endmodule

// ===== hw/rtl/dual_motor_deadband_ramp.sv =====
// ---------------------------------------------------------------------------
// dual_motor_deadband_ramp
// two-channel stick mapper with deadband and slew-limited duty
// ---------------------------------------------------------------------------
// Takes one item per clock cycle, back to back, and shows the result on rsp
// from the result register: the accepting edge loads the input stage, then
// a single pass through the command mapper (one constant multiply) or the
// ramp compare and clamp goes into the result register. A held-off result
// register stalls the input stage, and with it req_tready.
// A left or right command maps
// the stick value to a target: up to 2000 is direction 0, from 2095 is
// direction 1, in between is target zero with the direction kept. A tick
// moves both duties toward their targets by csr_data's ramp step and never
// past them. Every item returns one result with both duties and directions
// after its update. The ramp step resets to 50; the user must write it only
// while no item is in flight, as the block itself does not enforce this.
module dual_motor_deadband_ramp (
   input  logic                    clock,
   input  logic                    reset,
   // command / tick items
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,   // [11:0] command_value, rest zero
   input  logic [1:0]              req_tuser,   // [1:0] kind
   // results
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,   // [11:0] left_duty, [23:12] right_duty,
                                                // [24] left_direction,
                                                // [25] right_direction, rest zero
   // ramp step register
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  dmdr_pkg::duty_type      csr_data
);
   import dmdr_pkg::*;
`include "dual_motor_deadband_ramp_defines.svh"

   // input stage
   logic        stage_valid_ff, stage_valid_in;
   logic [1:0]  stage_kind_ff, stage_kind_in;
   duty_type    stage_cmd_ff, stage_cmd_in;

   // channel state
   duty_type    left_speed_ff, left_speed_in;
   duty_type    right_speed_ff, right_speed_in;
   duty_type    left_target_ff, left_target_in;
   duty_type    right_target_ff, right_target_in;
   logic        left_dir_ff, left_dir_in;
   logic        right_dir_ff, right_dir_in;
   duty_type    ramp_step_ff, ramp_step_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic           advance;
   logic           req_accept;
   map_result_type map_res;

   // the staged item moves on whenever the result register is free or draining
   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   dmdr_map u_map (
      .cmd    (stage_cmd_ff),
      .result (map_res)
   );

   // input stage
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_kind_in  = stage_kind_ff;
      stage_cmd_in   = stage_cmd_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
         stage_kind_in  = req_tuser;
         stage_cmd_in   = req_tdata[DUTY_W-1:0];
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   // state update for the staged item
   always_comb begin
      left_speed_in   = left_speed_ff;
      right_speed_in  = right_speed_ff;
      left_target_in  = left_target_ff;
      right_target_in = right_target_ff;
      left_dir_in     = left_dir_ff;
      right_dir_in    = right_dir_ff;
      if (advance) begin
         unique case (stage_kind_ff)
            KIND_LEFT: begin
               left_target_in = map_res.target;
               if (map_res.dir_load) left_dir_in = map_res.dir_val;
            end
            KIND_RIGHT: begin
               right_target_in = map_res.target;
               if (map_res.dir_load) right_dir_in = map_res.dir_val;
            end
            KIND_TICK: begin
               left_speed_in  = ramp_toward(left_speed_ff, left_target_ff, ramp_step_ff);
               right_speed_in = ramp_toward(right_speed_ff, right_target_ff, ramp_step_ff);
            end
            default: begin
               // unused kind only reports the state
            end
         endcase
      end
   end

   // ramp step register
   always_comb begin
      ramp_step_in = ramp_step_ff;
      if (csr_valid && csr_ready) ramp_step_in = csr_data;
   end

   // result register, loaded with the state after the update
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, right_dir_in, left_dir_in, right_speed_in, left_speed_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         left_speed_ff   <= '0;
         right_speed_ff  <= '0;
         left_target_ff  <= '0;
         right_target_ff <= '0;
         left_dir_ff     <= 1'b0;
         right_dir_ff    <= 1'b0;
         ramp_step_ff    <= RAMP_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stage_valid_ff  <= stage_valid_in;
         left_speed_ff   <= left_speed_in;
         right_speed_ff  <= right_speed_in;
         left_target_ff  <= left_target_in;
         right_target_ff <= right_target_in;
         left_dir_ff     <= left_dir_in;
         right_dir_ff    <= right_dir_in;
         ramp_step_ff    <= ramp_step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      stage_kind_ff <= stage_kind_in;
      stage_cmd_ff  <= stage_cmd_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // a stalled item stays in the input stage
   `DMDR_ASSERT_NEXT(a_stage_holds, clock, reset, stage_valid_ff && !advance,
      stage_valid_ff, "staged item dropped while stalled")

   // every processed item shows up on rsp
   `DMDR_ASSERT_NEXT(a_result_loaded, clock, reset, advance, rsp_valid_ff,
      "processed item produced no result")

   // duties only change on a tick
   `DMDR_ASSERT_NEXT(a_speed_tick_only, clock, reset,
      !(advance && (stage_kind_ff == KIND_TICK)),
      $stable(left_speed_ff) && $stable(right_speed_ff),
      "duty changed without a tick")

   // left duty ramping from below never overshoots its target
   `DMDR_ASSERT_NEXT(a_no_overshoot, clock, reset,
      advance && (stage_kind_ff == KIND_TICK) && (left_speed_ff <= left_target_ff),
      left_speed_ff <= left_target_ff, "left duty passed its target")

endmodule

// ===== test/tb_dual_motor_deadband_ramp.sv =====
// ---------------------------------------------------------------------------
// tb_dual_motor_deadband_ramp
// self-checking bench for the two-channel stick mapper and duty ramp
// ---------------------------------------------------------------------------
// A short scripted sequence runs first: extreme and boundary stick values,
// every item kind, the unused kind, and the zero and full-scale ramp steps.
// Rows whose result is obvious carry it typed in. Random phases follow, each
// with its own ramp step, and every result is checked against a behavioral
// copy of the mapper and ramp. Both stream sides idle in random bursts. One
// phase holds the result side off so the block backs up into its input.
// Another phase drains the pipe midway. The last phase runs with no idling.
module tb_dual_motor_deadband_ramp;

   import dmdr_pkg::*;

   // stick mapping and timing constants of the bench
   localparam int STICK_LOW_MAX  = 2000;
   localparam int STICK_HIGH_MIN = 2095;
   localparam int FULL_SCALE     = 4095;
   localparam int STEP_AT_RESET  = 50;
   localparam int SETTLE_CYCLES  = 4;      // covers the input stage and result register
   localparam int HOLD_CYCLES    = 48;     // long result-side hold-off
   localparam int STALL_LIMIT    = 1000;   // cycles with no handshake at all
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 100;

   // the block ignores the fourth kind code
   localparam logic [1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      duty_type left_duty;
      duty_type right_duty;
      logic     left_dir;
      logic     right_dir;
   } motor_status_type;

   typedef enum logic {ROW_ITEM, ROW_STEP} row_op_type;

   typedef struct packed {
      row_op_type       op;
      logic [1:0]       kind;
      logic [11:0]      value;     // stick value, or ramp step on a step row
      logic             typed;     // want holds the result
      motor_status_type want;
   } script_row_type;

   localparam int SCRIPT_ROWS = 27;

   // step starts at 50 after reset
   localparam script_row_type SCRIPT [0:SCRIPT_ROWS-1] = '{
      // a tick ignores its stick value, the unused kind changes nothing
      '{ROW_ITEM, KIND_TICK,  12'd4095, 1'b1, '{12'd0,   12'd0,   1'b0, 1'b0}},
      '{ROW_ITEM, KIND_NONE,  12'd4095, 1'b1, '{12'd0,   12'd0,   1'b0, 1'b0}},
      // top of the high range maps to full duty, direction 1
      '{ROW_ITEM, KIND_LEFT,  12'd4095, 1'b1, '{12'd0,   12'd0,   1'b1, 1'b0}},
      '{ROW_ITEM, KIND_RIGHT, 12'd0,    1'b1, '{12'd0,   12'd0,   1'b1, 1'b0}},
      '{ROW_ITEM, KIND_TICK,  12'd0,    1'b1, '{12'd50,  12'd0,   1'b1, 1'b0}},
      // top of the low range maps to full duty, direction 0
      '{ROW_ITEM, KIND_RIGHT, 12'd2000, 1'b1, '{12'd50,  12'd0,   1'b1, 1'b0}},
      '{ROW_ITEM, KIND_TICK,  12'd0,    1'b1, '{12'd100, 12'd50,  1'b1, 1'b0}},
      // deadband edges: target zero, direction kept
      '{ROW_ITEM, KIND_LEFT,  12'd2001, 1'b1, '{12'd100, 12'd50,  1'b1, 1'b0}},
      '{ROW_ITEM, KIND_TICK,  12'd0,    1'b1, '{12'd50,  12'd100, 1'b1, 1'b0}},
      '{ROW_ITEM, KIND_LEFT,  12'd2094, 1'b1, '{12'd50,  12'd100, 1'b1, 1'b0}},
      '{ROW_ITEM, KIND_TICK,  12'd0,    1'b1, '{12'd0,   12'd150, 1'b1, 1'b0}},
      // bottom of the high range
      '{ROW_ITEM, KIND_RIGHT, 12'd2095, 1'b1, '{12'd0,   12'd150, 1'b1, 1'b1}},
      '{ROW_ITEM, KIND_TICK,  12'd0,    1'b1, '{12'd0,   12'd100, 1'b1, 1'b1}},
      // small targets: the duty lands on them instead of passing
      '{ROW_ITEM, KIND_LEFT,  12'd1,    1'b1, '{12'd0,   12'd100, 1'b0, 1'b1}},
      '{ROW_ITEM, KIND_TICK,  12'd0,    1'b1, '{12'd2,   12'd50,  1'b0, 1'b1}},
      '{ROW_ITEM, KIND_RIGHT, 12'd2096, 1'b1, '{12'd2,   12'd50,  1'b0, 1'b1}},
      '{ROW_ITEM, KIND_TICK,  12'd0,    1'b1, '{12'd2,   12'd2,   1'b0, 1'b1}},
      '{ROW_ITEM, KIND_NONE,  12'd0,    1'b1, '{12'd2,   12'd2,   1'b0, 1'b1}},
      '{ROW_ITEM, KIND_RIGHT, 12'd1000, 1'b1, '{12'd2,   12'd2,   1'b0, 1'b0}},
      '{ROW_ITEM, KIND_LEFT,  12'd3000, 1'b0, '0},
      // full-scale step jumps straight to the targets
      '{ROW_STEP, KIND_TICK,  12'd4095, 1'b0, '0},
      '{ROW_ITEM, KIND_TICK,  12'd0,    1'b0, '0},
      '{ROW_ITEM, KIND_LEFT,  12'd4095, 1'b0, '0},
      // zero step freezes both duties
      '{ROW_STEP, KIND_TICK,  12'd0,    1'b0, '0},
      '{ROW_ITEM, KIND_TICK,  12'd4095, 1'b0, '0},
      '{ROW_ITEM, KIND_RIGHT, 12'd2730, 1'b0, '0},
      '{ROW_ITEM, KIND_TICK,  12'd1365, 1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [11:0] command_value, rest zero
   logic [1:0]  req_tuser;    // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [11:0] left_duty, [23:12] right_duty,
                              // [24] left_direction, [25] right_direction
   logic        csr_valid;
   logic        csr_ready;
   duty_type    csr_data;

   // behavioral copy of the block state
   duty_type step_now;
   duty_type left_duty_now;
   duty_type right_duty_now;
   duty_type left_target_now;
   duty_type right_target_now;
   logic     left_dir_now;
   logic     right_dir_now;

   motor_status_type pending_status_q [$];
   int               mismatches;
   int               quiet_cycles;
   bit               offering;
   bit               hold_request;
   int               req_idle_pct;
   int               rsp_stall_pct;

   dual_motor_deadband_ramp i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // stick value to target and direction; the deadband keeps the direction
   task automatic map_stick(input logic [11:0] stick, inout duty_type target,
                            inout logic dir);
      int value;
      value = int'(stick);
      if (value <= STICK_LOW_MAX) begin
         dir    = 1'b0;
         target = duty_type'(value * FULL_SCALE / STICK_LOW_MAX);
      end else if (value >= STICK_HIGH_MIN) begin
         dir    = 1'b1;
         target = duty_type'((value - STICK_HIGH_MIN) * FULL_SCALE / STICK_LOW_MAX);
      end else begin
         target = '0;
      end
   endtask

   // one slew step, landing on the target when it is within reach
   function automatic duty_type slew_duty(duty_type duty, duty_type target,
                                          duty_type step);
      int d;
      int t;
      int s;
      d = int'(duty);
      t = int'(target);
      s = int'(step);
      if (d < t)
         return (t - d <= s) ? target : duty_type'(d + s);
      if (d > t)
         return (d - t <= s) ? target : duty_type'(d - s);
      return duty;
   endfunction

   task automatic advance_motors(input logic [1:0] kind, input logic [11:0] stick,
                                 output motor_status_type status);
      case (kind)
         KIND_LEFT: begin
            map_stick(stick, left_target_now, left_dir_now);
         end
         KIND_RIGHT: begin
            map_stick(stick, right_target_now, right_dir_now);
         end
         KIND_TICK: begin
            left_duty_now  = slew_duty(left_duty_now, left_target_now, step_now);
            right_duty_now = slew_duty(right_duty_now, right_target_now, step_now);
         end
         default: begin
         end
      endcase
      status = '{left_duty_now, right_duty_now, left_dir_now, right_dir_now};
   endtask

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------

   // offer one item, hold it until taken, then record what it should give
   task automatic send_item(input logic [1:0] kind, input logic [11:0] stick,
                            input logic typed, input motor_status_type want);
      motor_status_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, stick};
      offering    = 1'b1;
      do @(posedge clock); while (!req_tready);
      advance_motors(kind, stick, predicted);
      pending_status_q.push_back(typed ? want : predicted);
   endtask

   // lower valid once, even when two callers end up in the same step
   task automatic stop_offer();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering    = 1'b0;
      end
   endtask

   task automatic maybe_gap();
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         stop_offer();
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // wait for every pending result, then let the pipe settle
   task automatic drain_pipe();
      stop_offer();
      wait (pending_status_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ramp_step(input duty_type value);
      drain_pipe();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      step_now   = value;
   endtask

   // random item: mostly ticks and in-range commands, boundary values often
   task automatic random_item();
      logic [1:0]  kind;
      logic [11:0] stick;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         kind = KIND_TICK;
      else if (pick < 70)
         kind = KIND_LEFT;
      else if (pick < 95)
         kind = KIND_RIGHT;
      else
         kind = KIND_NONE;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 7))
               0: stick = 12'd0;
               1: stick = 12'd1;
               2: stick = 12'd2000;
               3: stick = 12'd2001;
               4: stick = 12'd2094;
               5: stick = 12'd2095;
               6: stick = 12'd2096;
               default: stick = 12'd4095;
            endcase
         end
         1: stick = 12'($urandom_range(2001, 2094));
         2, 3: stick = 12'($urandom_range(0, 2000));
         4, 5, 6: stick = 12'($urandom_range(2095, 4095));
         default: stick = 12'($urandom_range(0, 4095));
      endcase
      send_item(kind, stick, 1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // receiver side: short stall bursts, or one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      motor_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status_q.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, got %h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_status_q.pop_front();
            compare_field("left_duty", want.left_duty, rsp_tdata[11:0]);
            compare_field("right_duty", want.right_duty, rsp_tdata[23:12]);
            compare_field("left_direction", want.left_dir, rsp_tdata[24]);
            compare_field("right_direction", want.right_dir, rsp_tdata[25]);
         end
      end
   end

   // watchdog: any handshake restarts the count
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_LEFT;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      offering      = 1'b0;
      hold_request  = 1'b0;
      mismatches    = 0;
      req_idle_pct  = 15;
      rsp_stall_pct = 15;
      step_now         = duty_type'(STEP_AT_RESET);
      left_duty_now    = '0;
      right_duty_now   = '0;
      left_target_now  = '0;
      right_target_now = '0;
      left_dir_now     = 1'b0;
      right_dir_now    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scripted part
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         if (SCRIPT[r].op == ROW_STEP) begin
            write_ramp_step(SCRIPT[r].value);
         end else begin
            send_item(SCRIPT[r].kind, SCRIPT[r].value, SCRIPT[r].typed, SCRIPT[r].want);
            maybe_gap();
         end
      end

      // random phases, one ramp step each, extremes included
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: write_ramp_step(duty_type'(STEP_AT_RESET));
            1: write_ramp_step(12'd1);
            2: write_ramp_step(12'd4095);
            3: write_ramp_step(12'd0);
            4: write_ramp_step(duty_type'($urandom_range(2, 200)));
            5: write_ramp_step(duty_type'($urandom_range(1, 4095)));
            6: write_ramp_step(12'd300);
            default: write_ramp_step(duty_type'($urandom_range(20, 120)));
         endcase
         // phase 5 is a clean stretch, the last phase runs without idling
         req_idle_pct  = (p == 5 || p == PHASE_COUNT - 1) ? 0 : 15;
         rsp_stall_pct = (p == 5 || p == PHASE_COUNT - 1) ? 0 : 15;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 30) begin
               // result side goes quiet while items keep coming back to back
               hold_request = 1'b1;
               for (int k = 0; k < 24; k++)
                  random_item();
            end else begin
               random_item();
            end
            if (p == 4 && n == 50)
               drain_pipe();
            else
               maybe_gap();
         end
      end

      drain_pipe();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_status_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== dual_motor_deadband_ramp.f =====
+incdir+hw/rtl
hw/rtl/dmdr_pkg.sv
hw/rtl/dmdr_map.sv
hw/rtl/dual_motor_deadband_ramp.sv
test/tb_dual_motor_deadband_ramp.sv
